@@ rtl/core/ibq_pkg.sv @@
`default_nettype none

package ibq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 32;
    localparam int WAIT_UNIT_US_DEF = 20;

    // command queue between the front and the back
    localparam int CMDQ_DEPTH = 2;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [7:0] ESCAPE_BYTE = 8'hFF;
    localparam logic [7:0] UNITS_MAX   = 8'd255;

    localparam logic [1:0] CMD_PUSH_DATA  = 2'd0;
    localparam logic [1:0] CMD_PUSH_DELAY = 2'd1;
    localparam logic [1:0] CMD_TICK       = 2'd2;

    localparam logic [1:0] STAT_NONE     = 2'd0;
    localparam logic [1:0] STAT_ACCEPTED = 2'd1;
    localparam logic [1:0] STAT_NO_ROOM  = 2'd2;
    localparam logic [1:0] STAT_RESERVED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_HOLD_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_TICKS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS       = 2'd3;

    localparam logic [6:0]  DEVICE_ADDRESS_RST  = 7'd0;
    localparam logic [15:0] SEND_HOLD_TICKS_RST = 16'd500;
    localparam logic [15:0] RETRY_TICKS_RST     = 16'd100;
    localparam logic [15:0] GAP_TICKS_RST       = 16'd100;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_DELAY,
        KIND_TICK,
        KIND_NOP
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  data_byte;
        logic [15:0] delay_us;
        logic        bus_busy;
    } in_item_t;

    typedef struct packed {
        logic [1:0] push_status;
        logic       send_valid;
        logic [6:0] send_address;
        logic [7:0] send_byte;
        logic       bus_claimed;
        logic       running;
        logic [5:0] free_slots;
    } out_item_t;

    // classified command as it travels from front to back
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data_byte;
        logic [7:0] units;
        logic       bus_busy;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] send_hold_ticks;
        logic [15:0] retry_ticks;
        logic [15:0] gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cmdq_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } cmdq_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/ibq_front.sv @@
`default_nettype none

module ibq_front
    import ibq_pkg::*;
#(
    parameter int WAIT_UNIT_US = WAIT_UNIT_US_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire in_item_t item,
    input  wire logic     q_full,
    output logic          busy,
    output logic          q_push,
    output cmd_t          q_data
);

    localparam int DIV_W    = 17;
    localparam int RECIP_SH = 24;
    localparam int PROD_W   = DIV_W + RECIP_SH + 1;
    localparam logic [RECIP_SH:0] RECIP =
        25'(((1 << RECIP_SH) + WAIT_UNIT_US - 1) / WAIT_UNIT_US);
    localparam logic [DIV_W-1:0] ROUND_ADD = DIV_W'(WAIT_UNIT_US - 1);
    localparam logic [DIV_W-1:0] SAT_LIMIT = DIV_W'(256 * WAIT_UNIT_US);

    logic              valid_reg;
    logic              valid_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic              accept;
    logic [DIV_W-1:0]  num;
    logic [PROD_W-1:0] prod;
    logic [7:0]        quo;
    logic [7:0]        units;

    assign busy   = valid_reg & q_full;
    assign accept = start & ~busy;
    assign q_push = valid_reg & ~q_full;
    assign q_data = cmd_reg;

    // ceil(us / unit) by reciprocal multiply, exact below the saturation limit
    always_comb
    begin
        num   = DIV_W'(item.delay_us) + ROUND_ADD;
        prod  = PROD_W'(num) * PROD_W'(RECIP);
        quo   = prod[RECIP_SH+7:RECIP_SH];
        units = (num >= SAT_LIMIT) ? UNITS_MAX : quo;
    end

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (q_push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next         = 1'b1;
            cmd_next.data_byte = item.data_byte;
            cmd_next.units     = units;
            cmd_next.bus_busy  = item.bus_busy;
            case (item.command)
                CMD_PUSH_DATA:  cmd_next.kind = KIND_DATA;
                CMD_PUSH_DELAY: cmd_next.kind = KIND_DELAY;
                CMD_TICK:       cmd_next.kind = KIND_TICK;
                default:        cmd_next.kind = KIND_NOP;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/ibq_cmdq.sv @@
`default_nettype none

module ibq_cmdq
    import ibq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmdq_ctrl_t ctrl,
    input  wire cmd_t       wdata,
    output cmdq_stat_t      stat,
    output cmd_t            rdata
);

    localparam int AW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          entries [CMDQ_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(CMDQ_DEPTH));
    assign do_push    = ctrl.push & ~stat.full;
    assign do_pop     = ctrl.pop & ~stat.empty;
    assign rdata      = entries[rd_ptr_reg];

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ibq_back.sv @@
`default_nettype none

module ibq_back
    import ibq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int WAIT_UNIT_US = WAIT_UNIT_US_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire cmdq_stat_t q_stat,
    input  wire cmd_t       q_head,
    output logic            q_pop,
    output logic            done,
    output out_item_t       result
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [7:0] UNIT8 = 8'(WAIT_UNIT_US);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DELAY2,
        S_STEP,
        S_POPPED,
        S_COUNT
    } state_t;

    typedef enum logic [1:0] {
        PH_POP,
        PH_SEND,
        PH_RELEASE,
        PH_DELAY_END
    } phase_t;

    logic [7:0]        mem [QUEUE_DEPTH];
    logic [7:0]        rd_data_reg;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    cmd_t              cmd_reg, cmd_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        held_reg, held_next;
    logic [15:0]       countdown_reg, countdown_next;
    logic              active_reg, active_next;
    logic              bus_hold_reg, bus_hold_next;
    logic              done_reg, done_next;
    out_item_t         result_reg, result_next;

    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic              emit;
    logic [1:0]        status;
    logic              send;
    logic [FILL_W+5:0] free_wide;

    assign done   = done_reg;
    assign result = result_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        fill_next      = fill_reg;
        held_next      = held_reg;
        countdown_next = countdown_reg;
        active_next    = active_reg;
        bus_hold_next  = bus_hold_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_wdata      = cmd_reg.data_byte;
        mem_re         = 1'b0;
        q_pop          = 1'b0;
        emit           = 1'b0;
        status         = STAT_NONE;
        send           = 1'b0;
        free_wide      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (cmd_reg.kind)
                    KIND_DATA:
                    begin
                        emit = 1'b1;
                        if (cmd_reg.data_byte == ESCAPE_BYTE)
                        begin
                            status = STAT_RESERVED;
                        end
                        else if (fill_reg == FILL_W'(QUEUE_DEPTH))
                        begin
                            status = STAT_NO_ROOM;
                        end
                        else
                        begin
                            status    = STAT_ACCEPTED;
                            mem_we    = 1'b1;
                            wp_next   = bump(wp_reg);
                            fill_next = fill_reg + 1'b1;
                            if (!active_reg)
                            begin
                                active_next    = 1'b1;
                                phase_next     = PH_POP;
                                countdown_next = '0;
                            end
                        end
                    end
                    KIND_DELAY:
                    begin
                        if (fill_reg > FILL_W'(QUEUE_DEPTH - 2))
                        begin
                            emit   = 1'b1;
                            status = STAT_NO_ROOM;
                        end
                        else
                        begin
                            // escape byte now, the count on the next cycle
                            mem_we     = 1'b1;
                            mem_wdata  = ESCAPE_BYTE;
                            wp_next    = bump(wp_reg);
                            fill_next  = fill_reg + 1'b1;
                            state_next = S_DELAY2;
                        end
                    end
                    KIND_TICK:
                    begin
                        if (!active_reg)
                        begin
                            emit = 1'b1;
                        end
                        else if (countdown_reg != '0)
                        begin
                            countdown_next = countdown_reg - 1'b1;
                            emit           = 1'b1;
                        end
                        else
                        begin
                            state_next = S_STEP;
                        end
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
            end

            S_DELAY2:
            begin
                emit      = 1'b1;
                status    = STAT_ACCEPTED;
                mem_we    = 1'b1;
                mem_wdata = cmd_reg.units;
                wp_next   = bump(wp_reg);
                fill_next = fill_reg + 1'b1;
                if (!active_reg)
                begin
                    active_next    = 1'b1;
                    phase_next     = PH_POP;
                    countdown_next = '0;
                end
            end

            S_STEP:
            begin
                case (phase_reg)
                    PH_POP:
                    begin
                        if (fill_reg == '0)
                        begin
                            active_next = 1'b0;
                            emit        = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            rp_next    = bump(rp_reg);
                            fill_next  = fill_reg - 1'b1;
                            state_next = S_POPPED;
                        end
                    end
                    PH_SEND:
                    begin
                        emit = 1'b1;
                        if (cmd_reg.bus_busy)
                        begin
                            countdown_next = cfg.retry_ticks;
                        end
                        else
                        begin
                            bus_hold_next  = 1'b1;
                            send           = 1'b1;
                            countdown_next = cfg.send_hold_ticks;
                            phase_next     = PH_RELEASE;
                        end
                    end
                    PH_RELEASE:
                    begin
                        emit          = 1'b1;
                        bus_hold_next = 1'b0;
                        phase_next    = PH_POP;
                        if (fill_reg == '0)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            countdown_next = cfg.gap_ticks;
                        end
                    end
                    default:
                    begin
                        // end of a delay: pop again within the same tick
                        phase_next = PH_POP;
                        if (fill_reg == '0)
                        begin
                            active_next = 1'b0;
                            emit        = 1'b1;
                        end
                    end
                endcase
            end

            S_POPPED:
            begin
                if (rd_data_reg == ESCAPE_BYTE)
                begin
                    if (fill_reg == '0)
                    begin
                        // escape without a count: zero-length delay
                        countdown_next = '0;
                        phase_next     = PH_DELAY_END;
                        emit           = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        rp_next    = bump(rp_reg);
                        fill_next  = fill_reg - 1'b1;
                        state_next = S_COUNT;
                    end
                end
                else
                begin
                    held_next  = rd_data_reg;
                    phase_next = PH_SEND;
                    state_next = S_STEP;
                end
            end

            S_COUNT:
            begin
                countdown_next = 16'(UNIT8) * 16'(rd_data_reg);
                phase_next     = PH_DELAY_END;
                emit           = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            state_next               = S_IDLE;
            done_next                = 1'b1;
            free_wide                = (FILL_W + 6)'(QUEUE_DEPTH) - (FILL_W + 6)'(fill_next);
            result_next.push_status  = status;
            result_next.send_valid   = send;
            result_next.send_address = send ? cfg.device_address : 7'd0;
            result_next.send_byte    = send ? held_reg : 8'd0;
            result_next.bus_claimed  = bus_hold_next;
            result_next.running      = active_next;
            result_next.free_slots   = free_wide[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_POP;
            wp_reg        <= '0;
            rp_reg        <= '0;
            fill_reg      <= '0;
            held_reg      <= '0;
            countdown_reg <= '0;
            active_reg    <= 1'b0;
            bus_hold_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            held_reg      <= held_next;
            countdown_reg <= countdown_next;
            active_reg    <= active_next;
            bus_hold_reg  <= bus_hold_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rp_reg];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_send_claims: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.send_valid |-> result_reg.bus_claimed && result_reg.running)
        else $error("send reported without bus claim");

    a_stopped_released: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> !bus_hold_reg)
        else $error("bus held while stopped");

    a_count_after_escape: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COUNT |-> $past(state_reg) == S_POPPED)
        else $error("delay count read without escape byte");

    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != S_IDLE)
        else $error("result transfer from idle");

endmodule

`default_nettype wire

@@ rtl/core/i2c_byte_queue_with_delays.sv @@
// Byte queue for single-byte I2C writes with delays, paced by microsecond ticks.
// An item is taken when start is high and busy is low; busy rises only while the
// front register and the two-entry command queue are both occupied. Each item
// gives exactly one result, shown on result for the single cycle in which done
// is high; the receiver cannot stall it. New items are taken into the front register
// and the two-entry command queue while the back sequencer works on an earlier one.
// The back sequencer handles one item at a time: a delay push writes the escape byte
// and then the count, and a tick that ends a delay can also pop and start a send, using
// its byte memory with a registered read. Configuration writes on cfg_write take
// effect at once and should only be made while idle.
`default_nettype none

module i2c_byte_queue_with_delays
    import ibq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int WAIT_UNIT_US = WAIT_UNIT_US_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire in_item_t              item,
    output logic                       busy,
    output logic                       done,
    output out_item_t                  result,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    cmdq_ctrl_t q_ctrl;
    cmdq_stat_t q_stat;
    cmd_t       q_wdata;
    cmd_t       q_head;
    logic       q_push;
    logic       q_pop;

    assign q_ctrl.push = q_push;
    assign q_ctrl.pop  = q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address  <= DEVICE_ADDRESS_RST;
            cfg_reg.send_hold_ticks <= SEND_HOLD_TICKS_RST;
            cfg_reg.retry_ticks     <= RETRY_TICKS_RST;
            cfg_reg.gap_ticks       <= GAP_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEVICE_ADDRESS:  cfg_reg.device_address  <= cfg_data[6:0];
                REG_SEND_HOLD_TICKS: cfg_reg.send_hold_ticks <= cfg_data;
                REG_RETRY_TICKS:     cfg_reg.retry_ticks     <= cfg_data;
                REG_GAP_TICKS:       cfg_reg.gap_ticks       <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    ibq_front #(
        .WAIT_UNIT_US (WAIT_UNIT_US)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .q_full (q_stat.full),
        .busy   (busy),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    ibq_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .wdata (q_wdata),
        .stat  (q_stat),
        .rdata (q_head)
    );

    ibq_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .WAIT_UNIT_US (WAIT_UNIT_US)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .q_head (q_head),
        .q_pop  (q_pop),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

@@ verif/i2c_byte_queue_with_delays_tb.sv @@
`timescale 1ns / 1ps

module i2c_byte_queue_with_delays_tb;
    import ibq_pkg::*;

    localparam int CYCLE_LIMIT = 600_000;
    localparam int PRINT_CAP   = 30;

    typedef enum logic [1:0] {
        SEQ_POP,
        SEQ_SEND,
        SEQ_RELEASE,
        SEQ_DELAY_END
    } seq_phase_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    in_item_t              cmd_item  = '0;
    logic                  busy;
    logic                  done;
    out_item_t             reply;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // stimulus and scoreboard
    in_item_t  stimulus_q[$];
    out_item_t expected_results[$];
    int        offered_count = 0;
    int        taken_count   = 0;
    int        error_count   = 0;
    int        cycle_count   = 0;
    int        sends_seen    = 0;
    int        refusals_seen = 0;
    bit        steady        = 1'b0;

    // predicted block state
    logic [7:0] ring[QUEUE_DEPTH_DEF];
    int         wr_slot   = 0;
    int         rd_slot   = 0;
    int         fill      = 0;
    seq_phase_t seq_phase = SEQ_POP;
    logic [7:0] held      = '0;
    logic [15:0] countdown = '0;
    bit         seq_running = 1'b0;
    bit         bus_hold    = 1'b0;

    // predicted configuration
    logic [6:0]  dev_addr   = DEVICE_ADDRESS_RST;
    logic [15:0] hold_ticks = SEND_HOLD_TICKS_RST;
    logic [15:0] retry_wait = RETRY_TICKS_RST;
    logic [15:0] gap_wait   = GAP_TICKS_RST;

    i2c_byte_queue_with_delays i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (cmd_item),
        .busy      (busy),
        .done      (done),
        .result    (reply),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void store_byte(input logic [7:0] b);
        ring[wr_slot] = b;
        wr_slot = (wr_slot + 1) % QUEUE_DEPTH_DEF;
        fill++;
    endfunction

    function automatic logic [7:0] pull_byte();
        logic [7:0] b;
        b = ring[rd_slot];
        rd_slot = (rd_slot + 1) % QUEUE_DEPTH_DEF;
        fill--;
        return b;
    endfunction

    function automatic void wake_sequencer();
        if (!seq_running) begin
            seq_running = 1'b1;
            seq_phase   = SEQ_POP;
            countdown   = '0;
        end
    endfunction

    // advance the predicted queue and sequencer by one item
    function automatic out_item_t predict_outcome(input in_item_t it);
        out_item_t  r;
        int         units;
        logic [7:0] b;
        logic [7:0] n;
        bit         again;
        r = '0;
        case (it.command)
            CMD_PUSH_DATA: begin
                if (it.data_byte == ESCAPE_BYTE) r.push_status = STAT_RESERVED;
                else if (fill >= QUEUE_DEPTH_DEF) r.push_status = STAT_NO_ROOM;
                else begin
                    store_byte(it.data_byte);
                    r.push_status = STAT_ACCEPTED;
                    wake_sequencer();
                end
            end
            CMD_PUSH_DELAY: begin
                if (QUEUE_DEPTH_DEF - fill < 2) r.push_status = STAT_NO_ROOM;
                else begin
                    units = (int'(it.delay_us) + WAIT_UNIT_US_DEF - 1) / WAIT_UNIT_US_DEF;
                    if (units > int'(UNITS_MAX)) units = int'(UNITS_MAX);
                    store_byte(ESCAPE_BYTE);
                    store_byte(units[7:0]);
                    r.push_status = STAT_ACCEPTED;
                    wake_sequencer();
                end
            end
            CMD_TICK: begin
                if (seq_running) begin
                    if (countdown != 0) countdown--;
                    else begin
                        again = 1'b1;
                        while (again) begin
                            again = 1'b0;
                            case (seq_phase)
                                SEQ_POP: begin
                                    if (fill == 0) seq_running = 1'b0;
                                    else begin
                                        b = pull_byte();
                                        if (b == ESCAPE_BYTE) begin
                                            // a missing count reads as zero
                                            n = (fill == 0) ? 8'd0 : pull_byte();
                                            countdown = 16'(WAIT_UNIT_US_DEF * int'(n));
                                            seq_phase = SEQ_DELAY_END;
                                        end else begin
                                            held = b;
                                            seq_phase = SEQ_SEND;
                                            again = 1'b1;
                                        end
                                    end
                                end
                                SEQ_SEND: begin
                                    if (it.bus_busy) countdown = retry_wait;
                                    else begin
                                        bus_hold       = 1'b1;
                                        r.send_valid   = 1'b1;
                                        r.send_address = dev_addr;
                                        r.send_byte    = held;
                                        countdown      = hold_ticks;
                                        seq_phase      = SEQ_RELEASE;
                                    end
                                end
                                SEQ_RELEASE: begin
                                    bus_hold  = 1'b0;
                                    seq_phase = SEQ_POP;
                                    if (fill == 0) seq_running = 1'b0;
                                    else countdown = gap_wait;
                                end
                                default: begin
                                    seq_phase = SEQ_POP;
                                    if (fill == 0) seq_running = 1'b0;
                                    else again = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
            default: ;
        endcase
        r.bus_claimed = bus_hold;
        r.running     = seq_running;
        r.free_slots  = 6'(QUEUE_DEPTH_DEF - fill);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // driver: one transfer offered at a time, held until taken
    always @(negedge clk) begin
        if (start && taken_count != offered_count) begin
            // still waiting for the transfer
        end else if (stimulus_q.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
            cmd_item <= stimulus_q.pop_front();
            start    <= 1'b1;
            offered_count++;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: check results first, then predict the item taken at this edge
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n) begin
            if (done) begin
                if (reply.send_valid === 1'b1) sends_seen++;
                if (reply.push_status === STAT_NO_ROOM || reply.push_status === STAT_RESERVED)
                    refusals_seen++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= PRINT_CAP)
                        $display("%0t: result %p with nothing expected", $time, reply);
                end else begin
                    want = expected_results.pop_front();
                    check_field("push_status", 16'(want.push_status), 16'(reply.push_status));
                    check_field("send_valid", 16'(want.send_valid), 16'(reply.send_valid));
                    check_field("send_address", 16'(want.send_address), 16'(reply.send_address));
                    check_field("send_byte", 16'(want.send_byte), 16'(reply.send_byte));
                    check_field("bus_claimed", 16'(want.bus_claimed), 16'(reply.bus_claimed));
                    check_field("running", 16'(want.running), 16'(reply.running));
                    check_field("free_slots", 16'(want.free_slots), 16'(reply.free_slots));
                end
            end
            if (start && !busy) begin
                expected_results.push_back(predict_outcome(cmd_item));
                taken_count++;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic in_item_t make_item(input logic [1:0] cmd, input logic [7:0] data,
                                           input logic [15:0] us, input logic busy_in);
        in_item_t it;
        it.command   = cmd;
        it.data_byte = data;
        it.delay_us  = us;
        it.bus_busy  = busy_in;
        return it;
    endfunction

    // unused fields carry random values so every bit toggles
    function automatic in_item_t random_item(input int push_pct);
        in_item_t it;
        int       r;
        it = make_item(CMD_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
        r  = $urandom_range(99);
        if (r < 4) begin
            if (r < 2) it.command = KIND_NOP;
            else begin
                it.command   = CMD_PUSH_DATA;
                it.data_byte = ESCAPE_BYTE;
            end
        end else if (r < push_pct) begin
            if ($urandom_range(3) != 0) begin
                it.command   = CMD_PUSH_DATA;
                it.data_byte = 8'($urandom_range(254));
            end else begin
                it.command  = CMD_PUSH_DELAY;
                it.delay_us = 16'($urandom_range(45));
            end
        end else begin
            it.bus_busy = ($urandom_range(99) < 30);
        end
        return it;
    endfunction

    task automatic add_random(input int count, input int push_pct);
        repeat (count) stimulus_q.push_back(random_item(push_pct));
    endtask

    task automatic add_ticks(input int count, input bit busy_in);
        repeat (count) stimulus_q.push_back(make_item(CMD_TICK, 8'($urandom),
                                                      16'($urandom), busy_in));
    endtask

    task automatic wait_for_drain();
        while (stimulus_q.size() != 0 || taken_count != offered_count || start
               || expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_DEVICE_ADDRESS:  dev_addr   = value[6:0];
            REG_SEND_HOLD_TICKS: hold_ticks = value;
            REG_RETRY_TICKS:     retry_wait = value;
            default:             gap_wait   = value;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] addr, input logic [15:0] hold_v,
                              input logic [15:0] retry_v, input logic [15:0] gap_v);
        write_reg(REG_DEVICE_ADDRESS, addr);
        write_reg(REG_SEND_HOLD_TICKS, hold_v);
        write_reg(REG_RETRY_TICKS, retry_v);
        write_reg(REG_GAP_TICKS, gap_v);
    endtask

    task automatic small_timing();
        set_timing(16'($urandom), 16'($urandom_range(6)), 16'($urandom_range(4)),
                   16'($urandom_range(6)));
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset timing: one send, then the full default hold before release
        stimulus_q.push_back(make_item(CMD_PUSH_DATA, 8'hA5, 16'($urandom), 1'b0));
        add_ticks(505, 1'b0);
        wait_for_drain();

        set_timing(16'h007F, 16'd1, 16'd1, 16'd0);
        stimulus_q.push_back(make_item(CMD_TICK, 8'h5A, 16'hFFFF, 1'b1));     // stopped
        stimulus_q.push_back(make_item(KIND_NOP, 8'hFF, 16'hA5A5, 1'b1));
        stimulus_q.push_back(make_item(CMD_PUSH_DATA, ESCAPE_BYTE, 16'h0, 1'b0));
        stimulus_q.push_back(make_item(CMD_PUSH_DELAY, 8'h00, 16'd0, 1'b0));  // zero units
        stimulus_q.push_back(make_item(CMD_PUSH_DATA, 8'h00, 16'h0, 1'b0));
        stimulus_q.push_back(make_item(CMD_PUSH_DELAY, 8'hFF, 16'd21, 1'b1)); // rounds up
        stimulus_q.push_back(make_item(CMD_PUSH_DATA, 8'hFE, 16'hFFFF, 1'b1));
        stimulus_q.push_back(make_item(CMD_PUSH_DELAY, 8'h00, 16'd20, 1'b0));
        stimulus_q.push_back(make_item(CMD_PUSH_DATA, 8'h80, 16'h0, 1'b0));
        add_ticks(2, 1'b1);   // delay end runs straight into a pop, bus is held off
        add_ticks(4, 1'b0);
        repeat (10) stimulus_q.push_back(make_item(CMD_TICK, 8'($urandom), 16'($urandom),
                                                   1'($urandom)));
        wait_for_drain();

        set_timing(16'd0, 16'd0, 16'd0, 16'd0);
        add_random(250, 35);
        wait_for_drain();

        small_timing();
        add_random(250, 55);
        wait_for_drain();

        // drain phase, with the sender held back until everything is back
        small_timing();
        add_random(120, 25);
        wait_for_drain();
        add_random(120, 25);
        wait_for_drain();

        small_timing();
        steady = 1'b1;
        add_random(250, 40);
        wait_for_drain();
        steady = 1'b0;

        small_timing();
        add_random(200, 45);
        wait_for_drain();

        // a delay long enough to saturate the unit count, behind what is queued
        set_timing(16'($urandom), 16'd0, 16'd0, 16'd0);
        stimulus_q.push_back(make_item(CMD_PUSH_DATA, 8'h3C, 16'h0, 1'b0));
        stimulus_q.push_back(make_item(CMD_PUSH_DELAY, 8'h00, 16'hFFFF, 1'b0));
        stimulus_q.push_back(make_item(CMD_PUSH_DATA, 8'hC3, 16'h0, 1'b0));
        add_ticks(100, 1'b0);
        wait_for_drain();

        set_timing(16'h007F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_random(80, 50);
        wait_for_drain();

        repeat (20) @(posedge clk);
        $display("Covered %0d transfers: %0d bytes sent, %0d pushes refused,", taken_count,
                 sends_seen, refusals_seen);
        $display("timing from zero to maximum, busy retries and a saturated delay push.");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ i2c_byte_queue_with_delays.f @@
rtl/core/ibq_pkg.sv
rtl/core/ibq_front.sv
rtl/core/ibq_cmdq.sv
rtl/core/ibq_back.sv
rtl/core/i2c_byte_queue_with_delays.sv
verif/i2c_byte_queue_with_delays_tb.sv
